[rtl/core/balance_pd_torque_controller_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the balance PD torque controller
// Concurrent checks, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALANCE_PD_TORQUE_CONTROLLER_ASSERT_SVH
`define BALANCE_PD_TORQUE_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/balpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balpd_pkg
// Shared widths, register map, datapath op codes and rounding/saturation
// helpers for the balance PD torque controller.
// ----------------------------------------------------------------------------
package balpd_pkg;

    // Stream and config port widths
    localparam int IN_W       = 112;
    localparam int OUT_W      = 96;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Datapath widths
    localparam int A_W    = 42;           // multiplier operand A, signed
    localparam int B_W    = 25;           // multiplier operand B, signed
    localparam int PW     = A_W + B_W;    // product
    localparam int SAT_W  = PW;           // saturation input width
    localparam int RND_W  = PW - 23;      // product after >>24 with rounding
    localparam int ACC_W  = 45;           // torque accumulators
    localparam int D_W    = 41;           // wheel differences
    localparam int ERR_W  = 33;           // tilt error

    // Sync term factors, Q0.24
    localparam logic signed [B_W-1:0] SYNC_ANGLE_GAIN = 25'sd3754937;
    localparam logic signed [B_W-1:0] SYNC_RATE_GAIN  = 25'sd187747;

    localparam logic [PW:0] RND_HALF = (PW+1)'(24'h800000);

    // Register map (index = paddr[5:3])
    typedef enum logic [2:0] {
        REG_TILT_PROP_GAIN  = 3'd0,
        REG_TILT_RATE_GAIN  = 3'd1,
        REG_WHEEL_PROP_GAIN = 3'd2,
        REG_WHEEL_RATE_GAIN = 3'd3,
        REG_LEAN_SETPOINT   = 3'd4,
        REG_TRAVEL_LIMIT    = 3'd5,
        REG_SAMPLE_PERIOD   = 3'd6,
        REG_SAMPLE_RATE     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [23:0] tilt_prop_gain;
        logic signed [23:0] tilt_rate_gain;
        logic signed [23:0] wheel_prop_gain;
        logic signed [23:0] wheel_rate_gain;
        logic signed [31:0] lean_setpoint;
        logic signed [39:0] travel_limit;
        logic        [23:0] sample_period;
        logic        [15:0] sample_rate;
    } t_cfg;

    // Reset values
    localparam logic signed [23:0] RST_TILT_PROP_GAIN  = -24'sd2508698;
    localparam logic signed [23:0] RST_TILT_RATE_GAIN  = -24'sd855363;
    localparam logic signed [23:0] RST_WHEEL_PROP_GAIN = -24'sd32768;
    localparam logic signed [23:0] RST_WHEEL_RATE_GAIN = -24'sd88906;
    localparam logic signed [31:0] RST_LEAN_SETPOINT   = 32'sd838861;
    localparam logic signed [39:0] RST_TRAVEL_LIMIT    = 40'sd436207616;
    localparam logic        [23:0] RST_SAMPLE_PERIOD   = 24'd16777;
    localparam logic        [15:0] RST_SAMPLE_RATE     = 16'd1000;

    // Datapath steps, issued in this order by the controller
    localparam int OP_W = 5;
    typedef enum logic [OP_W-1:0] {
        OP_NONE,
        OP_TILT_MUL,
        OP_TILT_ACC,
        OP_WHEEL,
        OP_DIFF,
        OP_MUL_RR,
        OP_MUL_LR,
        OP_MUL_TKP,
        OP_MUL_TKD,
        OP_MUL_WKP_R,
        OP_MUL_WKD_R,
        OP_MUL_WKP_L,
        OP_MUL_WKD_L,
        OP_MUL_SA,
        OP_MUL_SR,
        OP_LAST_ACC,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic capture;   // latch the input item
        logic load_out;  // load the output register
    } t_cmd;

    // Arithmetic shift right by 24, round half up
    function automatic logic signed [RND_W-1:0] rnd24(input logic signed [PW-1:0] p);
        logic [PW:0] t;
        t = (PW+1)'(p) + RND_HALF;
        return t[PW:24];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]))
            return v[31:0];
        return v[SAT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [SAT_W-1:0] v);
        if ((&v[SAT_W-1:39]) || !(|v[SAT_W-1:39]))
            return v[39:0];
        return v[SAT_W-1] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
    endfunction

endpackage

[rtl/core/balance_pd_torque_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance_pd_torque_controller
// Two-wheel balance loop: tilt integration, wheel angle/rate and PD torques.
//
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  gyro, right and left joint
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  right/left torque, tilt
// apb       in   psel/penable/pwrite/pready       8 registers at 8*index
//
// One item runs fifteen datapath steps, eleven of them products through the
// one shared multiplier, then the output load; tvalid rises with the loaded
// result and tready returns with it.
// One item is worked at a time; the next is taken while the result waits.
// A stalled output holds the finished result and delays the next result.
// Reset clears the tilt and the previous wheel angles and sets the registers to their reset values.
// ----------------------------------------------------------------------------
`include "balance_pd_torque_controller_assert.svh"

module balance_pd_torque_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] gyro_pitch_rate, [71:32] right_joint_angle, [111:72] left_joint_angle
    input  logic [balpd_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] right_torque, [63:32] left_torque, [95:64] tilt_estimate
    output logic [balpd_pkg::OUT_W-1:0]         o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [balpd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [balpd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [balpd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import balpd_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    balpd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    balpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (w_cmd)
    );

    balpd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cfg   (w_cfg),
        .i_data  (i_s_axis_tdata),
        .o_data  (o_m_axis_tdata)
    );

    // Only one item in flight at a time
    `BPD_ASSERT_NEXT(a_single_item, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second item taken while busy")
    // The output register is only loaded when its item has left
    `BPD_ASSERT_NOW(a_load_slot_free, w_cmd.load_out, !o_m_axis_tvalid || i_m_axis_tready, "output overwritten")
    // A new result appears only after a load
    `BPD_ASSERT_NOW(a_valid_after_load, $rose(o_m_axis_tvalid), $past(w_cmd.load_out), "result without load")

endmodule

[rtl/core/balpd_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balpd_regs
// APB-style register file holding gains, setpoint, travel limit and timing.
// ----------------------------------------------------------------------------
module balpd_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [balpd_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [balpd_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [balpd_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                                o_pready,
    output balpd_pkg::t_cfg                     o_cfg
);
    import balpd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[CFG_ADDR_W-1:3]);
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign o_cfg    = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_prop_gain  <= RST_TILT_PROP_GAIN;
            r_cfg.tilt_rate_gain  <= RST_TILT_RATE_GAIN;
            r_cfg.wheel_prop_gain <= RST_WHEEL_PROP_GAIN;
            r_cfg.wheel_rate_gain <= RST_WHEEL_RATE_GAIN;
            r_cfg.lean_setpoint   <= RST_LEAN_SETPOINT;
            r_cfg.travel_limit    <= RST_TRAVEL_LIMIT;
            r_cfg.sample_period   <= RST_SAMPLE_PERIOD;
            r_cfg.sample_rate     <= RST_SAMPLE_RATE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TILT_PROP_GAIN:  r_cfg.tilt_prop_gain  <= i_pwdata[23:0];
                REG_TILT_RATE_GAIN:  r_cfg.tilt_rate_gain  <= i_pwdata[23:0];
                REG_WHEEL_PROP_GAIN: r_cfg.wheel_prop_gain <= i_pwdata[23:0];
                REG_WHEEL_RATE_GAIN: r_cfg.wheel_rate_gain <= i_pwdata[23:0];
                REG_LEAN_SETPOINT:   r_cfg.lean_setpoint   <= i_pwdata[31:0];
                REG_TRAVEL_LIMIT:    r_cfg.travel_limit    <= i_pwdata[39:0];
                REG_SAMPLE_PERIOD:   r_cfg.sample_period   <= i_pwdata[23:0];
                REG_SAMPLE_RATE:     r_cfg.sample_rate     <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux, raw register bits zero-extended
    always_comb begin
        o_prdata = '0;
        unique case (w_idx)
            REG_TILT_PROP_GAIN:  o_prdata = CFG_DATA_W'($unsigned(r_cfg.tilt_prop_gain));
            REG_TILT_RATE_GAIN:  o_prdata = CFG_DATA_W'($unsigned(r_cfg.tilt_rate_gain));
            REG_WHEEL_PROP_GAIN: o_prdata = CFG_DATA_W'($unsigned(r_cfg.wheel_prop_gain));
            REG_WHEEL_RATE_GAIN: o_prdata = CFG_DATA_W'($unsigned(r_cfg.wheel_rate_gain));
            REG_LEAN_SETPOINT:   o_prdata = CFG_DATA_W'($unsigned(r_cfg.lean_setpoint));
            REG_TRAVEL_LIMIT:    o_prdata = CFG_DATA_W'($unsigned(r_cfg.travel_limit));
            REG_SAMPLE_PERIOD:   o_prdata = CFG_DATA_W'(r_cfg.sample_period);
            REG_SAMPLE_RATE:     o_prdata = CFG_DATA_W'(r_cfg.sample_rate);
            default:             o_prdata = '0;
        endcase
    end

endmodule

[rtl/core/balpd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balpd_ctrl
// Sequencer: takes one item, steps the datapath through its op list, then
// hands the result to the output register when that is free.
// ----------------------------------------------------------------------------
module balpd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output balpd_pkg::t_cmd     o_cmd
);
    import balpd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_ready, n_ready;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_m_tready;

    // Next state and registered outputs
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ready     = r_ready;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready)
            n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    n_state = S_RUN;
                    n_op    = OP_TILT_MUL;
                    n_ready = 1'b0;
                end
            end
            S_RUN: begin
                if (r_op == OP_LAST_ACC) begin
                    n_state = S_OUT;
                    n_op    = OP_OUT;
                end else begin
                    n_op = t_op'(OP_W'(r_op) + OP_W'(1));
                end
            end
            S_OUT: begin
                if (w_slot_free) begin
                    n_state     = S_IDLE;
                    n_op        = OP_NONE;
                    n_ready     = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_op    = OP_NONE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NONE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready     = r_ready;
    assign o_m_tvalid     = r_out_valid;
    assign o_cmd.op       = r_op;
    assign o_cmd.capture  = i_s_tvalid && r_ready;
    assign o_cmd.load_out = (r_state == S_OUT) && w_slot_free;

endmodule

[rtl/core/balpd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balpd_dp
// Datapath: one shared 42x25 signed multiplier with a product register,
// tilt integrator, wheel angle/rate registers and torque accumulators.
// ----------------------------------------------------------------------------
module balpd_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  balpd_pkg::t_cmd                 i_cmd,
    input  balpd_pkg::t_cfg                 i_cfg,
    input  logic [balpd_pkg::IN_W-1:0]      i_data,
    output logic [balpd_pkg::OUT_W-1:0]     o_data
);
    import balpd_pkg::*;

    // Latched input item
    logic signed [31:0]      r_gyro;
    logic signed [39:0]      r_rj;
    logic signed [39:0]      r_lj;

    // Loop state
    logic signed [31:0]      r_tilt;
    logic signed [39:0]      r_prev_r;
    logic signed [39:0]      r_prev_l;

    // Intermediate results
    logic signed [PW-1:0]    r_prod;
    logic signed [39:0]      r_rw, r_lw, r_rr, r_lr;
    logic signed [D_W-1:0]   r_dr, r_dl, r_dw, r_drr;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ACC_W-1:0] r_acc_c, r_acc_r, r_acc_l;
    logic [OUT_W-1:0]        r_out;

    logic signed [A_W-1:0]   w_mul_a;
    logic signed [B_W-1:0]   w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [RND_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_rnd_acc;
    logic signed [SAT_W-1:0] w_tilt_sum;
    logic signed [31:0]      w_setpoint;

    assign w_rnd      = rnd24(r_prod);
    assign w_rnd_acc  = ACC_W'(w_rnd);
    assign w_tilt_sum = SAT_W'(r_tilt) + SAT_W'(w_rnd);
    assign w_setpoint = (r_rj >= i_cfg.travel_limit) ? 32'sd0 : i_cfg.lean_setpoint;

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_TILT_MUL: begin
                w_mul_a = A_W'(r_gyro);
                w_mul_b = $signed({1'b0, i_cfg.sample_period});
            end
            OP_MUL_RR: begin
                w_mul_a = A_W'(r_dr);
                w_mul_b = $signed(B_W'(i_cfg.sample_rate));
            end
            OP_MUL_LR: begin
                w_mul_a = A_W'(r_dl);
                w_mul_b = $signed(B_W'(i_cfg.sample_rate));
            end
            OP_MUL_TKP: begin
                w_mul_a = A_W'(r_err);
                w_mul_b = B_W'(i_cfg.tilt_prop_gain);
            end
            OP_MUL_TKD: begin
                w_mul_a = A_W'(r_gyro);
                w_mul_b = B_W'(i_cfg.tilt_rate_gain);
            end
            OP_MUL_WKP_R: begin
                w_mul_a = A_W'(r_rw);
                w_mul_b = B_W'(i_cfg.wheel_prop_gain);
            end
            OP_MUL_WKD_R: begin
                w_mul_a = A_W'(r_rr);
                w_mul_b = B_W'(i_cfg.wheel_rate_gain);
            end
            OP_MUL_WKP_L: begin
                w_mul_a = A_W'(r_lw);
                w_mul_b = B_W'(i_cfg.wheel_prop_gain);
            end
            OP_MUL_WKD_L: begin
                w_mul_a = A_W'(r_lr);
                w_mul_b = B_W'(i_cfg.wheel_rate_gain);
            end
            OP_MUL_SA: begin
                w_mul_a = A_W'(r_dw);
                w_mul_b = SYNC_ANGLE_GAIN;
            end
            OP_MUL_SR: begin
                w_mul_a = A_W'(r_drr);
                w_mul_b = SYNC_RATE_GAIN;
            end
            default: ;
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    // Loop state: tilt and previous wheel angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt   <= '0;
            r_prev_r <= '0;
            r_prev_l <= '0;
        end else begin
            case (i_cmd.op)
                OP_TILT_ACC: r_tilt <= sat32(w_tilt_sum);
                OP_DIFF: begin
                    r_prev_r <= r_rw;
                    r_prev_l <= r_lw;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.capture) begin
            r_gyro <= i_data[31:0];
            r_rj   <= i_data[71:32];
            r_lj   <= i_data[111:72];
        end
        case (i_cmd.op)
            OP_WHEEL: begin
                r_rw  <= sat40(SAT_W'(r_rj) + SAT_W'(r_tilt));
                r_lw  <= sat40(SAT_W'(r_lj) + SAT_W'(r_tilt));
                r_err <= ERR_W'(w_setpoint) - ERR_W'(r_tilt);
            end
            OP_DIFF: begin
                r_dr <= D_W'(r_rw) - D_W'(r_prev_r);
                r_dl <= D_W'(r_lw) - D_W'(r_prev_l);
                r_dw <= D_W'(r_rw) - D_W'(r_lw);
            end
            OP_MUL_LR:    r_rr <= sat40(r_prod);
            OP_MUL_TKP:   r_lr <= sat40(r_prod);
            OP_MUL_TKD: begin
                r_acc_c <= w_rnd_acc;
                r_drr   <= D_W'(r_rr) - D_W'(r_lr);
            end
            OP_MUL_WKP_R: r_acc_c <= r_acc_c - w_rnd_acc;
            OP_MUL_WKD_R: r_acc_r <= r_acc_c - w_rnd_acc;
            OP_MUL_WKP_L: r_acc_r <= r_acc_r - w_rnd_acc;
            OP_MUL_WKD_L: r_acc_l <= r_acc_c - w_rnd_acc;
            OP_MUL_SA:    r_acc_l <= r_acc_l - w_rnd_acc;
            OP_MUL_SR:    r_acc_l <= r_acc_l + w_rnd_acc;
            OP_LAST_ACC:  r_acc_l <= r_acc_l + w_rnd_acc;
            default: ;
        endcase
        // Output register: tilt, left torque, right torque from MSB down
        if (i_cmd.load_out)
            r_out <= {r_tilt, sat32(SAT_W'(r_acc_l)), sat32(SAT_W'(r_acc_r))};
    end

    assign o_data = r_out;

endmodule
